### hw/rtl/assert_macros.svh
// Assertion helpers used by the console renderer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define ASSERT_NEVER(label, ck, rs, expr, msg) \
  label: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, ck, rs, prop, msg)
`define ASSERT_NEVER(label, ck, rs, expr, msg)
`endif
`endif

### hw/rtl/tcgr_pkg.sv
package tcgr_pkg;

  localparam int CODE_W      = 8;
  localparam int CURSOR_W    = 12;
  localparam int GW_W        = 5;
  localparam int GH_W        = 6;
  localparam int LOAD_ROW_W  = 5;
  localparam int GLYPH_ROW_W = 16;
  localparam int COLOR_W     = 24;
  localparam int KIND_W      = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  localparam int DEF_GLYPH_COUNT      = 256;
  localparam int DEF_MAX_GLYPH_HEIGHT = 32;
  localparam int DEF_MAX_GLYPH_WIDTH  = 16;
  localparam int DEF_TAB_CELLS        = 4;

  localparam int RST_GLYPH_WIDTH   = 8;
  localparam int RST_GLYPH_HEIGHT  = 16;
  localparam int RST_SCREEN_WIDTH  = 1024;
  localparam int RST_SCREEN_HEIGHT = 768;
  localparam logic [COLOR_W-1:0] RST_INK_COLOR = 24'h00ff00;

  localparam int MIN_SCREEN_WIDTH  = 16;
  localparam int MIN_SCREEN_HEIGHT = 32;

  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PAINT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd2;

  localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;

  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INK_COLOR     = 3'd4;

  typedef struct packed {
    logic                   op;
    logic [CODE_W-1:0]      char_code;
    logic [LOAD_ROW_W-1:0]  load_row;
    logic [GLYPH_ROW_W-1:0] load_bits;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [CURSOR_W-1:0]    pixel_x;
    logic [CURSOR_W-1:0]    pixel_y;
    logic [GLYPH_ROW_W-1:0] row_mask;
    logic [COLOR_W-1:0]     color;
    logic                   last;
  } out_item_t;

endpackage

### hw/rtl/text_console_glyph_renderer.sv
// channel | direction | handshake            | payload
// in      | to block  | in_valid / in_stall   | in_data (op, char_code, load_row, load_bits)
// out     | from block| out_valid / out_stall | out_data (kind, pixel_x/y, row_mask, color, last)
// cfg     | to block  | cfg_write             | cfg_index, cfg_data
//
// Glyph loads and newline are taken from idle; a newline that scrolls also gives a scroll result.
// A drawn or erased character gives glyph height rows at one a cycle while not stalled, set by the
// single glyph store read port; each row passes the store read register and the output register.
// Tab waits for the remainder unit, then settles the cursor on its done strobe.
// Reset clears cursor and registers to defaults; the glyph store is not cleared.
// out_stall holds the output register and pauses row reads; in_stall is high while busy.
module text_console_glyph_renderer import tcgr_pkg::*; #(
  parameter int GLYPH_COUNT      = DEF_GLYPH_COUNT,
  parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT,
  parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH,
  parameter int TAB_CELLS        = DEF_TAB_CELLS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int DEPTH   = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int GLYPH_W = $clog2(GLYPH_COUNT);
  localparam int ROW_W   = $clog2(MAX_GLYPH_HEIGHT);
  localparam int CNT_W   = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int STOP_W  = $clog2(TAB_CELLS * MAX_GLYPH_WIDTH + 1);
  localparam int EXT_W   = CURSOR_W + 2;
  localparam bit WRAP_CODE = GLYPH_COUNT < (1 << CODE_W);
  localparam logic [CODE_W:0] GC_CODE = (CODE_W + 1)'(WRAP_CODE ? GLYPH_COUNT : 0);
  localparam int GH_RESET = (RST_GLYPH_HEIGHT > MAX_GLYPH_HEIGHT) ?
                            MAX_GLYPH_HEIGHT : RST_GLYPH_HEIGHT;
  localparam int GW_RESET = (RST_GLYPH_WIDTH > MAX_GLYPH_WIDTH) ?
                            MAX_GLYPH_WIDTH : RST_GLYPH_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_TAB    = 4'b0010,
    S_SCROLL = 4'b0100,
    S_ROWS   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [GW_W-1:0]     gw;
  logic [GH_W-1:0]     gh;
  logic [CURSOR_W-1:0] sw;
  logic [CURSOR_W-1:0] sh;
  logic [COLOR_W-1:0]  ink;

  logic [CURSOR_W-1:0] cursor_x;
  logic [CURSOR_W-1:0] cursor_y;
  logic [CURSOR_W-1:0] base_x;
  logic [CURSOR_W-1:0] base_y;
  logic [GLYPH_W-1:0]  glyph_sel;
  logic                row_paint;
  logic                scroll_rows;
  logic                post_scroll;
  logic [CNT_W-1:0]    issue_cnt;
  logic                pend;
  logic [ROW_W-1:0]    pend_row;

  logic accept, is_load, acc_nl, acc_bs, acc_tab, acc_char;
  logic bs_same, bs_prev;
  logic out_free, out_load;
  logic row_issue, row_take, row_final;
  out_item_t out_next;

  logic [CODE_W:0]        glyph_code;
  logic [GLYPH_W-1:0]     glyph;
  logic [GLYPH_ROW_W-1:0] span;
  logic [STOP_W-1:0]      stop;

  logic [EXT_W-1:0] gw_ext, gh_ext, sw_ext, sh_ext, x_ext, y_ext;
  logic [EXT_W-1:0] ny, xa, xt;
  logic             lf_scroll, char_wrap, tab_wrap, bs_scroll;
  logic [CURSOR_W-1:0] lf_y, xb, xp, yb, yb2;

  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [GLYPH_ROW_W-1:0] mem_rdata;
  logic                   rem_done;
  logic [STOP_W-1:0]      rem_value;

  // configuration, kept clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      gw  <= GW_W'(GW_RESET);
      gh  <= GH_W'(GH_RESET);
      sw  <= CURSOR_W'(RST_SCREEN_WIDTH);
      sh  <= CURSOR_W'(RST_SCREEN_HEIGHT);
      ink <= RST_INK_COLOR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GLYPH_WIDTH: begin
          if (cfg_data[GW_W-1:0] == '0) begin
            gw <= GW_W'(1);
          end else if (cfg_data[GW_W-1:0] > GW_W'(MAX_GLYPH_WIDTH)) begin
            gw <= GW_W'(MAX_GLYPH_WIDTH);
          end else begin
            gw <= cfg_data[GW_W-1:0];
          end
        end
        CFG_GLYPH_HEIGHT: begin
          if (cfg_data[GH_W-1:0] == '0) begin
            gh <= GH_W'(1);
          end else if (cfg_data[GH_W-1:0] > GH_W'(MAX_GLYPH_HEIGHT)) begin
            gh <= GH_W'(MAX_GLYPH_HEIGHT);
          end else begin
            gh <= cfg_data[GH_W-1:0];
          end
        end
        CFG_SCREEN_WIDTH: begin
          if (cfg_data[CURSOR_W-1:0] < CURSOR_W'(MIN_SCREEN_WIDTH)) begin
            sw <= CURSOR_W'(MIN_SCREEN_WIDTH);
          end else begin
            sw <= cfg_data[CURSOR_W-1:0];
          end
        end
        CFG_SCREEN_HEIGHT: begin
          if (cfg_data[CURSOR_W-1:0] < CURSOR_W'(MIN_SCREEN_HEIGHT)) begin
            sh <= CURSOR_W'(MIN_SCREEN_HEIGHT);
          end else begin
            sh <= cfg_data[CURSOR_W-1:0];
          end
        end
        CFG_INK_COLOR: begin
          ink <= cfg_data[COLOR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_load  = (in_data.op == OP_LOAD);
  assign acc_nl   = accept && !is_load && (in_data.char_code == CHAR_NEWLINE);
  assign acc_bs   = accept && !is_load && (in_data.char_code == CHAR_BACKSPACE);
  assign acc_tab  = accept && !is_load && (in_data.char_code == CHAR_TAB);
  assign acc_char = accept && !is_load && !acc_nl && !acc_bs && !acc_tab;
  assign bs_same  = (cursor_x != '0);
  assign bs_prev  = (cursor_x == '0) && (cursor_y != '0);

  assign glyph_code = (WRAP_CODE && ({1'b0, in_data.char_code} >= GC_CODE)) ?
                      {1'b0, in_data.char_code} - GC_CODE : {1'b0, in_data.char_code};
  assign glyph      = GLYPH_W'(glyph_code);
  assign span       = GLYPH_ROW_W'(16'hFFFF << (GW_W'(GLYPH_ROW_W) - gw));
  assign stop       = STOP_W'(STOP_W'(TAB_CELLS) * STOP_W'(gw));

  assign gw_ext = EXT_W'(gw);
  assign gh_ext = EXT_W'(gh);
  assign sw_ext = EXT_W'(sw);
  assign sh_ext = EXT_W'(sh);
  assign x_ext  = EXT_W'(cursor_x);
  assign y_ext  = EXT_W'(cursor_y);

  assign ny        = y_ext + gh_ext;
  assign lf_scroll = (ny + gh_ext) >= sh_ext;
  assign lf_y      = lf_scroll ? cursor_y : ny[CURSOR_W-1:0];
  assign xa        = x_ext + gw_ext;
  assign char_wrap = (xa + gw_ext) > sw_ext;
  assign xt        = x_ext + EXT_W'(stop) - EXT_W'(rem_value);
  assign tab_wrap  = (xt + gw_ext) > sw_ext;

  assign xb = (cursor_x >= CURSOR_W'(gw)) ? cursor_x - CURSOR_W'(gw) : '0;
  assign xp = sw - CURSOR_W'(gw);
  assign yb = (cursor_y >= CURSOR_W'(gh)) ? cursor_y - CURSOR_W'(gh) : '0;
  assign bs_scroll = (EXT_W'(yb) + gh_ext) >= sh_ext;
  assign yb2 = !bs_scroll ? yb :
               ((yb >= CURSOR_W'(gh)) ? yb - CURSOR_W'(gh) : '0);

  assign out_free  = !out_valid || !out_stall;
  assign row_take  = (state == S_ROWS) && pend && out_free;
  assign row_final = (GH_W'(pend_row) == gh - GH_W'(1));
  assign row_issue = (state == S_ROWS) && (GH_W'(issue_cnt) < gh) && (!pend || out_free);

  assign mem_we    = accept && is_load &&
                     ({1'b0, in_data.load_row} < (LOAD_ROW_W + 1)'(MAX_GLYPH_HEIGHT));
  assign mem_waddr = ADDR_W'(ADDR_W'(glyph) * ADDR_W'(MAX_GLYPH_HEIGHT)
                     + ADDR_W'(in_data.load_row));
  assign mem_re    = row_issue;
  assign mem_raddr = ADDR_W'(ADDR_W'(glyph_sel) * ADDR_W'(MAX_GLYPH_HEIGHT)
                     + ADDR_W'(issue_cnt));

  tcgr_glyph_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_glyph_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.load_bits),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcgr_mod_unit #(
    .DIVISOR_W (STOP_W)
  ) u_mod_unit (
    .clk       (clk),
    .rst       (rst),
    .start     (acc_tab),
    .dividend  (cursor_x),
    .divisor   (stop),
    .done      (rem_done),
    .remainder (rem_value)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        priority if (acc_nl && lf_scroll) begin
          state_next = S_SCROLL;
        end else if (acc_bs && bs_same) begin
          state_next = S_ROWS;
        end else if (acc_bs && bs_prev) begin
          state_next = bs_scroll ? S_SCROLL : S_ROWS;
        end else if (acc_tab) begin
          state_next = S_TAB;
        end else if (acc_char) begin
          state_next = S_ROWS;
        end
      end
      S_TAB: begin
        if (rem_done) begin
          state_next = (tab_wrap && lf_scroll) ? S_SCROLL : S_IDLE;
        end
      end
      S_SCROLL: begin
        if (out_free) begin
          state_next = scroll_rows ? S_ROWS : S_IDLE;
        end
      end
      S_ROWS: begin
        if (row_take && row_final) begin
          state_next = post_scroll ? S_SCROLL : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (state == S_SCROLL) begin
      out_load      = out_free;
      out_next.kind = KIND_SCROLL;
      out_next.last = !scroll_rows;
    end else if (state == S_ROWS) begin
      out_load         = row_take;
      out_next.kind    = row_paint ? KIND_PAINT : KIND_CLEAR;
      out_next.pixel_x = base_x;
      out_next.pixel_y = base_y + CURSOR_W'(pend_row);
      out_next.row_mask = row_paint ? (mem_rdata & span) : span;
      out_next.color   = row_paint ? ink : '0;
      out_next.last    = row_final && !post_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cursor_x    <= '0;
      cursor_y    <= '0;
      scroll_rows <= 1'b0;
      post_scroll <= 1'b0;
      issue_cnt   <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (accept && !is_load) begin
        issue_cnt   <= '0;
        scroll_rows <= acc_bs;
        post_scroll <= acc_char && char_wrap && lf_scroll;
      end else if (row_issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end

      if (row_issue) begin
        pend <= 1'b1;
      end else if (row_take) begin
        pend <= 1'b0;
      end

      priority if (acc_nl) begin
        cursor_x <= '0;
        cursor_y <= lf_y;
      end else if (acc_bs && bs_same) begin
        cursor_x <= xb;
      end else if (acc_bs && bs_prev) begin
        cursor_x <= xp;
        cursor_y <= yb2;
      end else if (acc_char) begin
        cursor_x <= char_wrap ? '0 : xa[CURSOR_W-1:0];
        cursor_y <= char_wrap ? lf_y : cursor_y;
      end else if ((state == S_TAB) && rem_done) begin
        cursor_x <= tab_wrap ? '0 : xt[CURSOR_W-1:0];
        cursor_y <= tab_wrap ? lf_y : cursor_y;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_bs && bs_same) begin
      base_x    <= xb;
      base_y    <= cursor_y;
      row_paint <= 1'b0;
    end else if (acc_bs && bs_prev) begin
      base_x    <= xp;
      base_y    <= yb2;
      row_paint <= 1'b0;
    end else if (acc_char) begin
      base_x    <= cursor_x;
      base_y    <= cursor_y;
      glyph_sel <= glyph;
      row_paint <= 1'b1;
    end
    if (row_issue) begin
      pend_row <= issue_cnt[ROW_W-1:0];
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  `ASSERT_NEVER(a_pend_outside_rows, clk, rst, pend && (state != S_ROWS), "row pending outside row phase")
  `ASSERT_NEVER(a_mem_collide, clk, rst, mem_we && mem_re, "glyph store written and read together")
  `ASSERT_NEVER(a_out_overwrite, clk, rst, out_load && out_valid && out_stall, "stalled result overwritten")
  `ASSERT_ALWAYS(a_issue_bound, clk, rst, (state == S_ROWS) |-> (GH_W'(issue_cnt) <= gh), "rows issued beyond glyph height")

endmodule

### hw/rtl/tcgr_glyph_mem.sv
module tcgr_glyph_mem import tcgr_pkg::*; #(
  parameter int DEPTH  = DEF_GLYPH_COUNT * DEF_MAX_GLYPH_HEIGHT,
  parameter int ADDR_W = $clog2(DEF_GLYPH_COUNT * DEF_MAX_GLYPH_HEIGHT)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [GLYPH_ROW_W-1:0] wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [GLYPH_ROW_W-1:0] rdata
);

  logic [GLYPH_ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tcgr_mod_unit.sv
module tcgr_mod_unit import tcgr_pkg::*; #(
  parameter int DIVISOR_W = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CURSOR_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIVISOR_W-1:0] remainder
);

  localparam int STEP_W = $clog2(CURSOR_W);

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [CURSOR_W-1:0]  num;
  logic [DIVISOR_W-1:0] den;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   den_ext;

  assign trial   = {remainder, num[CURSOR_W-1]};
  assign den_ext = {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(CURSOR_W - 1);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      num       <= dividend;
      den       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (trial >= den_ext) begin
        remainder <= DIVISOR_W'(trial - den_ext);
      end else begin
        remainder <= DIVISOR_W'(trial);
      end
    end
  end

endmodule
